>>> design/sis_pkg.sv
// ----------------------------------------------------------------------------
// sis_pkg
// Shared types for the stream insertion sorter: beat payloads and the
// command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package sis_pkg;

    localparam int VALUE_W = 32;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      last;
    } item_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value_res;
        logic                      last_res;
        logic                      dropped;
    } result_t;

    typedef struct packed {
        logic capture;
        logic mark_drop;
        logic rd_prev;
        logic shift;
        logic place;
        logic rd_out;
        logic out_load;
        logic out_pop;
        logic next_out;
        logic clear;
    } sis_cmd_t;

    typedef struct packed {
        logic full;
        logic last;
        logic pos_zero;
        logic greater;
        logic final_beat;
    } sis_status_t;

endpackage

>>> design/stream_insertion_sorter_unit.sv
// ----------------------------------------------------------------------------
// stream_insertion_sorter_unit
// Stable ascending insertion sort of signed 32-bit values; a set is drained
// in order after its last value, then the store is cleared.
//
//   channel | payload  | handshake
//   item    | item_t   | item_valid / item_stall
//   result  | result_t | result_valid / result_stall
//
// Per item, each step reads the next stored entry down; each entry larger
// than the item is shifted up one place, and the item is placed above the
// first entry not larger, or at the bottom. Full store: item dropped.
// Drain: each beat is read, registered and held while result_stall is high.
// Reset clears fill count and drop flag; store contents need no reset.
// item_stall is high from acceptance until insertion and any drain complete.
// ----------------------------------------------------------------------------
module stream_insertion_sorter_unit
    import sis_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_stall,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    sis_cmd_t    cmd;
    sis_status_t status;

    sis_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .result_stall (result_stall),
        .status       (status),
        .cmd          (cmd)
    );

    sis_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cmd          (cmd),
        .status       (status),
        .result       (result),
        .result_valid (result_valid)
    );

endmodule

>>> design/sis_ram.sv
// ----------------------------------------------------------------------------
// sis_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module sis_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> design/sis_dpath.sv
// ----------------------------------------------------------------------------
// sis_dpath
// Sorter datapath: sorted store, insertion pointer, fill count, drop flag,
// drain index and the result register.
// ----------------------------------------------------------------------------
module sis_dpath
    import sis_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  item_t       item,
    input  sis_cmd_t    cmd,
    output sis_status_t status,
    output result_t     result,
    output logic        result_valid
);

    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int FILL_W = $clog2(CAPACITY + 1);

    logic signed [VALUE_W-1:0] v_reg;
    logic                      last_reg;
    logic [ADDR_W-1:0]         pos_reg;
    logic [FILL_W-1:0]         fill_reg;
    logic                      ovf_reg;
    logic [ADDR_W-1:0]         k_reg;
    result_t                   out_reg;
    logic                      out_valid_reg;

    logic                      wr_en;
    logic [VALUE_W-1:0]        wr_data;
    logic                      rd_en;
    logic [ADDR_W-1:0]         rd_addr;
    logic [VALUE_W-1:0]        rd_data;

    assign wr_en   = cmd.shift | cmd.place;
    assign wr_data = cmd.shift ? rd_data : VALUE_W'(v_reg);
    assign rd_en   = cmd.rd_prev | cmd.rd_out;
    assign rd_addr = cmd.rd_prev ? (pos_reg - ADDR_W'(1)) : k_reg;

    sis_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (pos_reg),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            v_reg    <= item.value;
            last_reg <= item.last;
            pos_reg  <= fill_reg[ADDR_W-1:0];
        end
        else if (cmd.shift)
        begin
            pos_reg <= pos_reg - ADDR_W'(1);
        end
        if (cmd.out_load)
        begin
            out_reg.value_res <= $signed(rd_data);
            out_reg.last_res  <= status.final_beat;
            out_reg.dropped   <= ovf_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            ovf_reg       <= 1'b0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear)
            begin
                fill_reg <= '0;
                ovf_reg  <= 1'b0;
                k_reg    <= '0;
            end
            else
            begin
                if (cmd.place)
                begin
                    fill_reg <= fill_reg + FILL_W'(1);
                end
                if (cmd.mark_drop)
                begin
                    ovf_reg <= 1'b1;
                end
                if (cmd.next_out)
                begin
                    k_reg <= k_reg + ADDR_W'(1);
                end
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (cmd.out_pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.full       = (fill_reg == FILL_W'(CAPACITY));
    assign status.last       = last_reg;
    assign status.pos_zero   = (pos_reg == '0);
    assign status.greater    = ($signed(rd_data) > v_reg);
    assign status.final_beat = ((FILL_W'(k_reg) + FILL_W'(1)) == fill_reg);

    assign result       = out_reg;
    assign result_valid = out_valid_reg;

endmodule

>>> design/sis_ctrl.sv
// ----------------------------------------------------------------------------
// sis_ctrl
// Sorter controller: takes one item, drops it on a full store, else walks the
// store down shifting larger entries up, places it, drains a beat at a time.
// ----------------------------------------------------------------------------
module sis_ctrl
    import sis_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  logic        result_stall,
    input  sis_status_t status,
    output sis_cmd_t    cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RD    = 3'd1;
    localparam logic [2:0] S_CMP   = 3'd2;
    localparam logic [2:0] S_ORD   = 3'd3;
    localparam logic [2:0] S_OLD   = 3'd4;
    localparam logic [2:0] S_OWAIT = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign item_stall = (state_reg != S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_RD;
                end
            end
            S_RD:
            begin
                if (status.full)
                begin
                    cmd.mark_drop = 1'b1;
                    state_next    = status.last ? S_ORD : S_IDLE;
                end
                else if (status.pos_zero)
                begin
                    cmd.place  = 1'b1;
                    state_next = status.last ? S_ORD : S_IDLE;
                end
                else
                begin
                    cmd.rd_prev = 1'b1;
                    state_next  = S_CMP;
                end
            end
            S_CMP:
            begin
                if (status.greater)
                begin
                    cmd.shift  = 1'b1;
                    state_next = S_RD;
                end
                else
                begin
                    cmd.place  = 1'b1;
                    state_next = status.last ? S_ORD : S_IDLE;
                end
            end
            S_ORD:
            begin
                cmd.rd_out = 1'b1;
                state_next = S_OLD;
            end
            S_OLD:
            begin
                cmd.out_load = 1'b1;
                state_next   = S_OWAIT;
            end
            S_OWAIT:
            begin
                if (!result_stall)
                begin
                    cmd.out_pop = 1'b1;
                    if (status.final_beat)
                    begin
                        cmd.clear  = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.next_out = 1'b1;
                        state_next   = S_ORD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

>>> design/sis_checker.sv
// ----------------------------------------------------------------------------
// sis_checker
// Port-level checks on the sorter: input and output never overlap, a run
// ends cleanly, and a stalled result beat holds.
// ----------------------------------------------------------------------------
module sis_checker
    import sis_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    item_valid,
    input logic    item_stall,
    input item_t   item,
    input logic    result_valid,
    input logic    result_stall,
    input result_t result
);

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result beat changed");

    assert property (@(posedge clk) disable iff (!rst_n)
        !(item_valid && !item_stall && result_valid))
    else $error("item taken while a result beat is pending");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_stall && result.last_res |=> !result_valid)
    else $error("result beat after end of run");

    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall && !item.last |=> !result_valid && item_stall)
    else $error("result or acceptance straight after a non-final item");

endmodule

bind stream_insertion_sorter_unit sis_checker u_sis_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);

>>> tb/sv/stream_insertion_sorter_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stream_insertion_sorter_unit_tb
// Drives sets of signed values into the sorter and checks every drained beat
// against a local stable insertion sort. A short table of edge values comes
// first. Random sets follow, the full-store and dropped-value cases among
// them, under three idle patterns on the two channels.
// ----------------------------------------------------------------------------
module stream_insertion_sorter_unit_tb
    import sis_pkg::*;
;

    localparam int DEPTH = 64;
    localparam logic signed [VALUE_W-1:0] MOST_NEG = {1'b1, {(VALUE_W-1){1'b0}}};
    localparam logic signed [VALUE_W-1:0] MOST_POS = {1'b0, {(VALUE_W-1){1'b1}}};

    typedef struct {
        item_t   stim;
        bit      typed;
        result_t want;
    } dir_row_t;

    logic    clk          = 1'b0;
    logic    rst_n        = 1'b0;
    logic    item_valid   = 1'b0;
    logic    item_stall;
    item_t   item         = '0;
    logic    result_valid;
    logic    result_stall = 1'b0;
    result_t result;

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;

    logic signed [VALUE_W-1:0] sort_list [DEPTH];
    int      sort_fill = 0;
    bit      sort_over = 1'b0;
    result_t sorted_due [$];
    result_t fresh_beats [$];
    dir_row_t dir_rows [$];

    int errors     = 0;
    int items_sent = 0;
    int beats_seen = 0;
    int sets_done  = 0;
    int drop_sets  = 0;

    stream_insertion_sorter_unit #(
        .CAPACITY(DEPTH)
    ) uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_stall  (item_stall),
        .item        (item),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result      (result)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    always @(negedge clk)
    begin
        result_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        errors++;
        if (errors <= 40)
            $display("%0t ns: mismatch on %s: got %h, want %h", $time, what, got, want);
    endtask

    // stable insertion; drains the whole list into fresh_beats on last
    task automatic sort_accept(input item_t it);
        int pos;
        fresh_beats.delete();
        if (sort_fill < DEPTH)
        begin
            pos = sort_fill;
            while (pos > 0 && sort_list[pos-1] > it.value)
            begin
                sort_list[pos] = sort_list[pos-1];
                pos--;
            end
            sort_list[pos] = it.value;
            sort_fill++;
        end
        else
        begin
            sort_over = 1'b1;
        end
        if (it.last)
        begin
            for (int k = 0; k < sort_fill; k++)
                fresh_beats.push_back('{value_res: sort_list[k],
                                        last_res:  (k == sort_fill - 1),
                                        dropped:   sort_over});
            sets_done++;
            if (sort_over)
                drop_sets++;
            sort_fill = 0;
            sort_over = 1'b0;
        end
    endtask

    // entered and left at a falling edge; valid stays high on return
    task automatic send_beat(input item_t it, input bit typed, input result_t want);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid = 1'b0;
            @(negedge clk);
        end
        item       = it;
        item_valid = 1'b1;
        do
            @(posedge clk);
        while (item_stall !== 1'b0);
        sort_accept(it);
        items_sent++;
        if (typed)
            sorted_due.push_back(want);
        else
            foreach (fresh_beats[k])
                sorted_due.push_back(fresh_beats[k]);
        @(negedge clk);
    endtask

    function automatic logic signed [VALUE_W-1:0] pick_value();
        int unsigned sel;
        sel = $urandom_range(9);
        case (sel)
            0:       return MOST_NEG;
            1:       return MOST_POS;
            2, 3, 4: return $signed($urandom_range(16)) - 8;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_set(input int n);
        item_t it;
        for (int i = 0; i < n; i++)
        begin
            it.value = pick_value();
            it.last  = (i == n - 1);
            send_beat(it, 1'b0, '0);
        end
    endtask

    task automatic hold_until_drained();
        item_valid = 1'b0;
        while (sorted_due.size() != 0)
            @(negedge clk);
    endtask

    function automatic dir_row_t mk_row(input logic signed [VALUE_W-1:0] v, input bit l,
                                        input bit typed,
                                        input logic signed [VALUE_W-1:0] wv = '0,
                                        input bit wl = 1'b0, input bit wd = 1'b0);
        dir_row_t r;
        r.stim  = '{value: v, last: l};
        r.typed = typed;
        r.want  = '{value_res: wv, last_res: wl, dropped: wd};
        return r;
    endfunction

    always @(posedge clk)
    begin : beat_check
        result_t want;
        if (rst_n && result_valid === 1'b1 && result_stall === 1'b0)
        begin
            beats_seen++;
            if (sorted_due.size() == 0)
            begin
                flag_mismatch("unexpected beat", result.value_res, '0);
            end
            else
            begin
                want = sorted_due.pop_front();
                if (result.value_res !== want.value_res)
                    flag_mismatch("value_res", result.value_res, want.value_res);
                if (result.last_res !== want.last_res)
                    flag_mismatch("last_res", 32'(result.last_res), 32'(want.last_res));
                if (result.dropped !== want.dropped)
                    flag_mismatch("dropped", 32'(result.dropped), 32'(want.dropped));
            end
        end
    end

    initial
    begin : stimulus
        int budget;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // single-value sets straight after reset, then small sets
        dir_rows.push_back(mk_row(MOST_NEG, 1'b1, 1'b1, MOST_NEG, 1'b1, 1'b0));
        dir_rows.push_back(mk_row(MOST_POS, 1'b1, 1'b1, MOST_POS, 1'b1, 1'b0));
        dir_rows.push_back(mk_row(0, 1'b1, 1'b1, 0, 1'b1, 1'b0));
        dir_rows.push_back(mk_row(-1, 1'b1, 1'b1, -1, 1'b1, 1'b0));
        dir_rows.push_back(mk_row(5, 1'b0, 1'b0));
        dir_rows.push_back(mk_row(-3, 1'b0, 1'b0));
        dir_rows.push_back(mk_row(5, 1'b0, 1'b0));
        dir_rows.push_back(mk_row(MOST_POS, 1'b0, 1'b0));
        dir_rows.push_back(mk_row(MOST_NEG, 1'b1, 1'b0));
        dir_rows.push_back(mk_row(3, 1'b0, 1'b0));
        dir_rows.push_back(mk_row(2, 1'b0, 1'b0));
        dir_rows.push_back(mk_row(1, 1'b0, 1'b0));
        dir_rows.push_back(mk_row(0, 1'b1, 1'b0));
        dir_rows.push_back(mk_row(-2, 1'b0, 1'b0));
        dir_rows.push_back(mk_row(-1, 1'b0, 1'b0));
        dir_rows.push_back(mk_row(0, 1'b0, 1'b0));
        dir_rows.push_back(mk_row(1, 1'b1, 1'b0));
        dir_rows.push_back(mk_row(7, 1'b0, 1'b0));
        dir_rows.push_back(mk_row(7, 1'b0, 1'b0));
        dir_rows.push_back(mk_row(7, 1'b1, 1'b0));
        dir_rows.push_back(mk_row(MOST_POS, 1'b0, 1'b0));
        dir_rows.push_back(mk_row(MOST_NEG, 1'b0, 1'b0));
        dir_rows.push_back(mk_row(MOST_POS, 1'b1, 1'b0));
        dir_rows.push_back(mk_row(32'sh55555555, 1'b0, 1'b0));
        dir_rows.push_back(mk_row(32'shAAAAAAAA, 1'b1, 1'b0));

        send_idle_pct = 15;
        recv_idle_pct = 50;
        foreach (dir_rows[r])
            send_beat(dir_rows[r].stim, dir_rows[r].typed, dir_rows[r].want);
        hold_until_drained();

        for (int ph = 0; ph < 3; ph++)
        begin
            case (ph)
                0:
                begin
                    send_idle_pct = 15;
                    recv_idle_pct = 50;
                end
                1:
                begin
                    send_idle_pct = 50;
                    recv_idle_pct = 15;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            // exactly full once, then over-full with values dropped
            if (ph == 0)
                send_set(DEPTH);
            else if (ph == 1)
                send_set(DEPTH + $urandom_range(1, 4));
            budget = items_sent + 12;
            while (items_sent < budget)
                send_set(($urandom_range(7) == 0) ? 1 : $urandom_range(2, 12));
            hold_until_drained();
        end

        repeat (300) @(posedge clk);
        if (sorted_due.size() != 0)
            flag_mismatch("beats never delivered", sorted_due.size(), 0);

        $display("sent %0d values in %0d sets (%0d over-full), checked %0d sorted beats",
                 items_sent, sets_done, drop_sets, beats_seen);
        $display("idle mixes: sender 15/receiver 50, sender 50/receiver 15, none");
        if (errors == 0)
            $display("stream_insertion_sorter_unit_tb OK");
        else
            $display("stream_insertion_sorter_unit_tb NOT OK");
        $finish;
    end

    initial
    begin : watchdog
        #2_000_000;
        $display("timeout with %0d beats outstanding", sorted_due.size());
        $display("stream_insertion_sorter_unit_tb NOT OK");
        $finish;
    end

endmodule
